// File: rtl/core/hybrid_split_size_table_core_macros.svh
// assertion helpers used by the checker
`ifndef HYBRID_SPLIT_SIZE_TABLE_CORE_MACROS_SVH
`define HYBRID_SPLIT_SIZE_TABLE_CORE_MACROS_SVH

// same-cycle implication, off while reset is low
`define HSST_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsst check failed");

// next-cycle implication, off while reset is low
`define HSST_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsst check failed");

`endif

// File: rtl/core/hsst_pkg.sv
package hsst_pkg;

    localparam int MAX_POLES_DEF = 1024;
    localparam int COUNT_W       = 16;
    localparam int SIZE_W        = 32;
    localparam int PRESET_COUNT  = 5;
    localparam int FILL_RESET    = 4;

    localparam int C_HEAD2  = 3;
    localparam int C_BODY2  = 5;
    localparam int C_HEAD4  = 13;
    localparam int C_TAIL1  = 1;
    localparam int C_TAIL2  = 4;
    localparam int C_TAIL3  = 9;
    localparam int C_TAIL4  = 14;
    localparam int C_B41    = 17;
    localparam int C_B42    = 18;
    localparam int C_B4FULL = 19;
    localparam int C_B4ZHAO = 18;

    // constant parts of the 2-way cost, folded together
    localparam logic [SIZE_W-1:0] C2_OFS_EVEN = SIZE_W'(C_HEAD2 + C_TAIL2 - 2 * C_BODY2);
    localparam logic [SIZE_W-1:0] C2_OFS_ODD  = SIZE_W'(C_HEAD2 + C_TAIL1 - C_BODY2);

    typedef struct packed {
        logic              four_way;
        logic [SIZE_W-1:0] size;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic t_entry preset_entry(input logic [2:0] idx);
        t_entry e;
        e.four_way = 1'b0;
        unique case (idx)
            3'd0:    e.size = SIZE_W'(0);
            3'd1:    e.size = SIZE_W'(1);
            3'd2:    e.size = SIZE_W'(2);
            3'd3:    e.size = SIZE_W'(3);
            3'd4:    e.size = SIZE_W'(6);
            default: e.size = SIZE_W'(0);
        endcase
        return e;
    endfunction

    // constant part of the 4-way cost once body*(q) is taken out
    function automatic logic [SIZE_W-1:0] c4_offset(input logic [1:0] lane, input logic zhao);
        int b;
        int v;
        b = zhao ? C_B4ZHAO : C_B4FULL;
        unique case (lane)
            2'd0: v = C_HEAD4 + C_TAIL4 - 2 * b;
            2'd1: v = C_B41 + C_HEAD4 + C_TAIL1 - 2 * b;
            2'd2: v = C_B42 + C_HEAD4 + C_TAIL2 - 2 * b;
            2'd3: v = C_HEAD4 + C_TAIL3 - b;
        endcase
        return SIZE_W'(v);
    endfunction

endpackage

// File: rtl/core/hsst_if.sv
interface hsst_req_if;
    import hsst_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] pole_count;

    modport source (output valid, output pole_count, input ready);
    modport sink   (input valid, input pole_count, output ready);
endinterface

interface hsst_rsp_if;
    import hsst_pkg::*;

    logic              valid;
    logic              ready;
    logic              four_way;
    logic [SIZE_W-1:0] circuit_size;
    logic              out_of_range;

    modport source (output valid, output four_way, output circuit_size,
                    output out_of_range, input ready);
    modport sink   (input valid, input four_way, input circuit_size,
                    input out_of_range, output ready);
endinterface

// File: rtl/core/hsst_table_mem.sv
module hsst_table_mem #(
    parameter int DEPTH = 1024,
    parameter int W     = 33,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [W-1:0]  o_rdata_a,
    output logic [W-1:0]  o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata_a;
    logic [W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/core/hsst_cost.sv
module hsst_cost #(
    parameter int AW = 10
) (
    input  logic                       i_clk,
    input  logic [AW-1:0]              i_j,
    input  logic                       i_zhao,
    input  logic [hsst_pkg::SIZE_W-1:0] i_lo,
    input  logic [hsst_pkg::SIZE_W-1:0] i_hi,
    input  logic [hsst_pkg::SIZE_W-1:0] i_hm1,
    input  logic [hsst_pkg::SIZE_W-1:0] i_h,
    output logic [hsst_pkg::SIZE_W-1:0] o_c2,
    output logic [hsst_pkg::SIZE_W-1:0] o_c4
);
    import hsst_pkg::*;

    logic [SIZE_W-1:0] q;
    logic [SIZE_W-1:0] h;
    logic [SIZE_W-1:0] body4;
    logic [SIZE_W-1:0] bq;
    logic [SIZE_W-1:0] parts4;
    logic [SIZE_W-1:0] c2;
    logic [SIZE_W-1:0] c4;
    logic [SIZE_W-1:0] r_c2;
    logic [SIZE_W-1:0] r_c4;

    always_comb begin
        q     = SIZE_W'(i_j >> 2);
        h     = SIZE_W'(i_j >> 1);
        body4 = i_zhao ? SIZE_W'(C_B4ZHAO) : SIZE_W'(C_B4FULL);
        bq    = q * body4;

        // weights of the two quarter entries follow j mod 4
        unique case (i_j[1:0])
            2'd0: parts4 = i_lo << 2;
            2'd1: parts4 = (i_lo << 1) + i_lo + i_hi;
            2'd2: parts4 = (i_lo << 1) + (i_hi << 1);
            2'd3: parts4 = i_lo + (i_hi << 1) + i_hi;
        endcase
        c4 = parts4 + bq + c4_offset(i_j[1:0], i_zhao);

        if (i_j[0]) begin
            c2 = i_hm1 + i_h + (h << 2) + h + C2_OFS_ODD;
        end else begin
            c2 = (i_hm1 << 1) + (h << 2) + h + C2_OFS_EVEN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c2 <= c2;
        r_c4 <= c4;
    end

    assign o_c2 = r_c2;
    assign o_c4 = r_c4;

endmodule

// File: rtl/core/hybrid_split_size_table_core.sv
// a count already in the table answers by way of S_LOOK, S_LDATA and S_RESP
// a count past the filled entries runs S_RDQ, S_RDH, S_CALC, S_WR per missing entry
// (two reads on the dual-read table memory, one cost register, compare and write back)
// out of range counts go straight to S_RESP; one query in flight at a time
// reset: zhao mode 0, table filled through entry 4; entries 0 to 4 come from
// constants, so no clearing pass; a mode write also drops the table back to entry 4
module hybrid_split_size_table_core #(
    parameter int MAX_POLES = hsst_pkg::MAX_POLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hsst_req_if.sink          i_req,
    hsst_rsp_if.source        o_rsp,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);
    import hsst_pkg::*;

    localparam int AW = $clog2(MAX_POLES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDQ,
        S_RDH,
        S_CALC,
        S_WR,
        S_LOOK,
        S_LDATA,
        S_RESP
    } t_state;

    t_state             r_state;
    logic               r_zhao;
    logic [AW-1:0]      r_filled;
    logic [AW-1:0]      r_j;
    logic [COUNT_W-1:0] r_n;
    t_entry             r_lo;
    t_entry             r_hi;
    t_entry             r_res;
    logic               r_res_oor;
    logic               r_rsp_valid;
    t_entry             r_out;
    logic               r_out_oor;
    logic [AW-1:0]      r_ra_q;
    logic [AW-1:0]      r_rb_q;

    logic [AW-1:0]      ra;
    logic [AW-1:0]      rb;
    logic [ENTRY_W-1:0] rd_a;
    logic [ENTRY_W-1:0] rd_b;
    t_entry             word_a;
    t_entry             word_b;
    logic [SIZE_W-1:0]  c2;
    logic [SIZE_W-1:0]  c4;
    t_entry             new_entry;
    logic               mem_we;
    logic               req_oor;
    logic [AW-1:0]      q_idx;
    logic [AW-1:0]      h_idx;

    always_comb begin
        q_idx = r_j >> 2;
        h_idx = r_j >> 1;
        unique case (r_state)
            S_RDQ: begin
                ra = q_idx - AW'(1);
                rb = q_idx;
            end
            S_RDH: begin
                ra = h_idx - AW'(1);
                rb = h_idx;
            end
            S_LOOK: begin
                ra = r_n[AW-1:0];
                rb = r_n[AW-1:0];
            end
            default: begin
                ra = '0;
                rb = '0;
            end
        endcase
    end

    // preset entries never live in the memory
    always_comb begin
        word_a = (r_ra_q < AW'(PRESET_COUNT)) ? preset_entry(r_ra_q[2:0]) : t_entry'(rd_a);
        word_b = (r_rb_q < AW'(PRESET_COUNT)) ? preset_entry(r_rb_q[2:0]) : t_entry'(rd_b);
    end

    // tie goes to the 4-way split
    always_comb begin
        if (c2 < c4) begin
            new_entry.four_way = 1'b0;
            new_entry.size     = c2;
        end else begin
            new_entry.four_way = 1'b1;
            new_entry.size     = c4;
        end
    end

    assign mem_we  = (r_state == S_WR);
    assign req_oor = ({1'b0, i_req.pole_count} >= (COUNT_W + 1)'(MAX_POLES));

    hsst_table_mem #(
        .DEPTH (MAX_POLES),
        .W     (ENTRY_W),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_j),
        .i_wdata   (new_entry),
        .i_raddr_a (ra),
        .i_raddr_b (rb),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    hsst_cost #(
        .AW (AW)
    ) u_cost (
        .i_clk  (i_clk),
        .i_j    (r_j),
        .i_zhao (r_zhao),
        .i_lo   (r_lo.size),
        .i_hi   (r_hi.size),
        .i_hm1  (word_a.size),
        .i_h    (word_b.size),
        .o_c2   (c2),
        .o_c4   (c4)
    );

    always_ff @(posedge i_clk) begin
        r_ra_q <= ra;
        r_rb_q <= rb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zhao      <= 1'b0;
            r_filled    <= AW'(FILL_RESET);
            r_rsp_valid <= 1'b0;
        end else begin
            // a new word may replace the one taken in the same cycle
            if (r_state == S_RESP && (!r_rsp_valid || o_rsp.ready)) begin
                r_rsp_valid <= 1'b1;
            end else if (r_rsp_valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_zhao   <= i_cfg_wdata;
                r_filled <= AW'(FILL_RESET);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_n <= i_req.pole_count;
                        if (req_oor) begin
                            r_res     <= '0;
                            r_res_oor <= 1'b1;
                            r_state   <= S_RESP;
                        end else if (i_req.pole_count[AW-1:0] <= r_filled) begin
                            r_state <= S_LOOK;
                        end else begin
                            r_j     <= r_filled + AW'(1);
                            r_state <= S_RDQ;
                        end
                    end
                end
                S_RDQ: begin
                    r_state <= S_RDH;
                end
                S_RDH: begin
                    r_lo    <= word_a;
                    r_hi    <= word_b;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_filled <= r_j;
                    if (r_j == r_n[AW-1:0]) begin
                        r_res     <= new_entry;
                        r_res_oor <= 1'b0;
                        r_state   <= S_RESP;
                    end else begin
                        r_j     <= r_j + AW'(1);
                        r_state <= S_RDQ;
                    end
                end
                S_LOOK: begin
                    r_state <= S_LDATA;
                end
                S_LDATA: begin
                    r_res     <= word_a;
                    r_res_oor <= 1'b0;
                    r_state   <= S_RESP;
                end
                S_RESP: begin
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_out     <= r_res;
                        r_out_oor <= r_res_oor;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.four_way     = r_out.four_way;
    assign o_rsp.circuit_size = r_out.size;
    assign o_rsp.out_of_range = r_out_oor;

endmodule

// File: rtl/core/hsst_checker.sv
`include "hybrid_split_size_table_core_macros.svh"

module hsst_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic                        i_rsp_four_way,
    input logic [hsst_pkg::SIZE_W-1:0] i_rsp_circuit_size,
    input logic                        i_rsp_out_of_range
);
    import hsst_pkg::*;

    // one query in flight: a taken word closes the input side
    `HSST_ASSERT_NXT(a_one_query, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // out of range words carry no size and no choice
    `HSST_ASSERT_IMP(a_oor_zero, i_clk, i_rst_n, i_rsp_valid && i_rsp_out_of_range, !i_rsp_four_way && (i_rsp_circuit_size == '0))

    `HSST_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    `HSST_ASSERT_NXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_rsp_circuit_size) && $stable(i_rsp_four_way) && $stable(i_rsp_out_of_range))

endmodule

bind hybrid_split_size_table_core hsst_checker u_hsst_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_four_way     (o_rsp.four_way),
    .i_rsp_circuit_size (o_rsp.circuit_size),
    .i_rsp_out_of_range (o_rsp.out_of_range)
);

// File: tb/sv/hybrid_split_size_table_core_tb.sv
module hybrid_split_size_table_core_tb;
    import hsst_pkg::*;

    localparam int POLES = MAX_POLES_DEF;
    localparam bit MODE_FULL = 1'b0;
    localparam bit MODE_ZHAO = 1'b1;
    localparam int PHASE_ITEMS = 305;

    typedef struct {
        bit                four_way;
        bit [SIZE_W-1:0]   circuit_size;
        bit                out_of_range;
    } split_answer_t;

    // mirrors the lazily grown split table and keeps the answers still owed
    class split_table_board;
        bit [SIZE_W-1:0] sizes [POLES];
        bit              ways [POLES];
        int              filled;
        bit              zhao;
        split_answer_t   owed [$];
        int              errors;

        function new();
            zhao = MODE_FULL;
            errors = 0;
            restart_table();
        endfunction

        function void restart_table();
            foreach (sizes[i]) begin
                sizes[i] = '0;
                ways[i] = 1'b0;
            end
            sizes[1] = 1;
            sizes[2] = 2;
            sizes[3] = 3;
            sizes[4] = 6;
            filled = FILL_RESET;
        endfunction

        function void set_mode(bit m);
            zhao = m;
            restart_table();
        endfunction

        // 2-way vs 4-way cost for one new entry, all terms wrap at 32 bits
        function void compute_entry(int j);
            bit [SIZE_W-1:0] q, h, bf, lo, hi, c2, c4;
            q = j / 4;
            h = j / 2;
            bf = zhao ? C_B4ZHAO : C_B4FULL;
            lo = sizes[q - 1];
            hi = sizes[q];
            if (j % 2 == 0) begin
                c2 = 2 * sizes[h - 1] + C_BODY2 * (h - 3) + C_BODY2 + C_TAIL2 + C_HEAD2;
            end else begin
                c2 = sizes[h - 1] + sizes[h] + C_BODY2 * (h - 2) + C_BODY2 + C_HEAD2
                     + C_TAIL1;
            end
            case (j % 4)
                0: begin
                    c4 = 4 * lo + bf * (q - 3) + bf + C_HEAD4 + C_TAIL4;
                end
                3: begin
                    c4 = lo + 3 * hi + bf * (q - 2) + bf + C_HEAD4 + C_TAIL3;
                end
                2: begin
                    c4 = 2 * lo + 2 * hi + bf * (q - 2) + C_B42 + C_HEAD4 + C_TAIL2;
                end
                default: begin
                    c4 = 3 * lo + hi + bf * (q - 2) + C_B41 + C_HEAD4 + C_TAIL1;
                end
            endcase
            if (c2 < c4) begin
                sizes[j] = c2;
                ways[j] = 1'b0;
            end else begin
                sizes[j] = c4;
                ways[j] = 1'b1;
            end
        endfunction

        function void note_query(bit [COUNT_W-1:0] cnt);
            split_answer_t a;
            if (cnt >= POLES) begin
                a.four_way = 1'b0;
                a.circuit_size = '0;
                a.out_of_range = 1'b1;
            end else begin
                while (filled < cnt) begin
                    filled++;
                    compute_entry(filled);
                end
                a.four_way = ways[cnt];
                a.circuit_size = sizes[cnt];
                a.out_of_range = 1'b0;
            end
            owed = {owed, a};
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(bit fw, bit [SIZE_W-1:0] sz, bit oor);
            split_answer_t a;
            if (owed.size() == 0) begin
                report($sformatf("unexpected word four_way=%0d size=%0d oor=%0d", fw, sz, oor));
            end else begin
                a = owed.pop_front();
                if (fw !== a.four_way)
                    report($sformatf("four_way %0d, want %0d", fw, a.four_way));
                if (sz !== a.circuit_size)
                    report($sformatf("circuit_size %0d, want %0d", sz, a.circuit_size));
                if (oor !== a.out_of_range)
                    report($sformatf("out_of_range %0d, want %0d", oor, a.out_of_range));
            end
        endtask

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    hsst_req_if req ();
    hsst_rsp_if rsp ();

    hybrid_split_size_table_core #(
        .MAX_POLES (POLES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_rsp       (rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    split_table_board board;
    bit steady;

    bit [COUNT_W-1:0] probes [20] = '{
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13,
        1023, 600, 1024, 65535, 32768, 1022
    };
    bit modes [6] = '{MODE_ZHAO, MODE_FULL, MODE_FULL, MODE_ZHAO, MODE_ZHAO, MODE_FULL};

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int idle_cycles();
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic bit [COUNT_W-1:0] draw_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return COUNT_W'($urandom_range(0, POLES - 1));
        else if (pick < 80)
            return COUNT_W'($urandom_range(0, 40));
        else if (pick < 92)
            return COUNT_W'($urandom_range(0, 65535));
        else
            return COUNT_W'($urandom_range(POLES, 65535));
    endfunction

    // valid stays high after a word is taken; the next negedge decides
    task automatic send_query(bit [COUNT_W-1:0] cnt);
        int gap;
        gap = idle_cycles();
        repeat (gap) begin
            @(negedge i_clk);
            req.valid = 1'b0;
        end
        @(negedge i_clk);
        req.valid = 1'b1;
        req.pole_count = cnt;
        do @(posedge i_clk); while (!req.ready);
        board.note_query(cnt);
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
    endtask

    task automatic drain();
        @(negedge i_clk);
        req.valid = 1'b0;
        while (board.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_mode(bit m);
        drain();
        repeat (6) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = m;
        board.set_mode(m);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // result side: random stalls, one word per draw
    initial begin
        int gap;
        rsp.ready = 1'b0;
        while (i_rst_n !== 1'b1)
            @(negedge i_clk);
        forever begin
            gap = idle_cycles();
            repeat (gap) begin
                @(negedge i_clk);
                rsp.ready = 1'b0;
            end
            @(negedge i_clk);
            rsp.ready = 1'b1;
            do @(posedge i_clk); while (!rsp.valid);
            board.check_result(rsp.four_way, rsp.circuit_size, rsp.out_of_range);
        end
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        board = new();
        steady = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        req.valid = 1'b0;
        req.pole_count = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (probes[i])
            send_query(probes[i]);

        foreach (modes[p]) begin
            write_mode(modes[p]);
            // small counts right after the table drops back
            send_query(4);
            send_query(5);
            repeat (PHASE_ITEMS)
                send_query(draw_count());
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
